/* hdl/text_console_cell_writer_assert.svh */
// assertion macros for the console rtl
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define TCCW_ASSERT_NOW(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// condition must hold in the cycle after the trigger
`define TCCW_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tccw_pkg.sv */
package tccw_pkg;

  // screen geometry
  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = COLS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLS + 1);
  localparam int ROW_W      = $clog2(ROWS + 1);
  localparam int CELL_W     = 16;

  // character codes
  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] TAB_CODE     = 8'd9;
  localparam logic [7:0] SPACE_CODE   = 8'd32;
  localparam int         TAB_SPACES   = 4;
  localparam int         TAB_W        = $clog2(TAB_SPACES);

  // operations
  localparam logic [2:0] OP_PUT_CHAR     = 3'd0;
  localparam logic [2:0] OP_PUT_AT       = 3'd1;
  localparam logic [2:0] OP_SET_CURSOR   = 3'd2;
  localparam logic [2:0] OP_CLEAR_SCREEN = 3'd3;
  localparam logic [2:0] OP_CLEAR_LINE   = 3'd4;
  localparam logic [2:0] OP_READ_CELL    = 3'd5;

  // configuration registers
  localparam logic REG_TEXT_COLOR = 1'b0;
  localparam logic REG_BACK_COLOR = 1'b1;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] data;
  } ram_wr_t;

  function automatic logic [CELL_W-1:0] make_cell(input logic [7:0] ch,
                                                  input logic [3:0] fg,
                                                  input logic [3:0] bg);
    make_cell = {bg, fg, ch};
  endfunction

  localparam logic [CELL_W-1:0] RESET_BLANK = make_cell(SPACE_CODE, 4'd15, 4'd0);

endpackage

/* hdl/tccw_screen_ram.sv */
module tccw_screen_ram (
  input  logic                            clk,
  input  tccw_pkg::ram_wr_t               wr,
  input  logic [tccw_pkg::ADDR_W-1:0]     rd_addr,
  output logic [tccw_pkg::CELL_W-1:0]     rd_data
);

  logic [tccw_pkg::CELL_W-1:0] mem [tccw_pkg::CELL_COUNT];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/text_console_cell_writer.sv */
// text console cell writer: a character-cell screen of COLS x ROWS 16-bit cells
// (character in the low byte, foreground in bits 11..8, background in 15..12)
// held in one single-port-write, registered-read memory, plus a cursor. an item
// is taken on in_valid & in_ready and yields exactly one result item with the
// cursor after the operation. ready is high only while the sequencer is idle,
// but a finished result waits in the output register so the next item can be
// taken before it is collected. each item is sequenced over the one memory
// port: read cell waits for the registered read; set cursor takes one modulo
// subtraction step per cycle, the larger of pos_x/COLS and pos_y/ROWS steps
// (up to 10 at 80x25); clear line sweeps COLS cells and clear screen all
// COLS*ROWS cells; a tab is four character steps; any character that needs
// a scroll first runs the scroll check, the row-copy sweep and the blank
// fill.
// after reset a clearing pass writes the blank white-on-black cell to all
// COLS*ROWS entries with ready low; config writes are still taken during it.
`include "text_console_cell_writer_assert.svh"

module text_console_cell_writer (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [7:0]  char_code,
  input  logic [3:0]  cell_text_color,
  input  logic [3:0]  cell_back_color,
  input  logic [7:0]  pos_x,
  input  logic [7:0]  pos_y,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  cursor_x,
  output logic [4:0]  cursor_y,
  output logic [15:0] cell_value,
  output logic        range_error
);

  localparam int COLS       = tccw_pkg::COLS;
  localparam int ROWS       = tccw_pkg::ROWS;
  localparam int CELL_COUNT = tccw_pkg::CELL_COUNT;
  localparam int ADDR_W     = tccw_pkg::ADDR_W;
  localparam int COL_W      = tccw_pkg::COL_W;
  localparam int ROW_W      = tccw_pkg::ROW_W;
  localparam int CELL_W     = tccw_pkg::CELL_W;
  localparam int TAB_W      = tccw_pkg::TAB_W;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELL_COUNT - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE       = 4'd0;
  localparam logic [3:0] S_DECODE     = 4'd1;
  localparam logic [3:0] S_EMIT       = 4'd2;
  localparam logic [3:0] S_SCROLL     = 4'd3;
  localparam logic [3:0] S_SCROLL_END = 4'd4;
  localparam logic [3:0] S_FILL       = 4'd5;
  localparam logic [3:0] S_MOD        = 4'd6;
  localparam logic [3:0] S_RDWAIT     = 4'd7;
  localparam logic [3:0] S_RESP       = 4'd8;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(COLS) + ADDR_W'(col);
  endfunction

  logic [3:0]        state, state_next;

  // latched item
  logic [2:0]        op_r;
  logic [7:0]        ch_r;
  logic [3:0]        fg_r, bg_r;
  logic [7:0]        px_r, py_r;

  // configuration
  logic [3:0]        text_color, back_color;

  // cursor
  logic [COL_W-1:0]  cur_col, cur_col_next;
  logic [ROW_W-1:0]  cur_row, cur_row_next;

  // tab repeat count and modulo working values
  logic [TAB_W-1:0]  tab_left, tab_left_next;
  logic [7:0]        mx, mx_next, my, my_next;

  // fill sweep
  logic [ADDR_W-1:0] fill_addr, fill_addr_next;
  logic [ADDR_W-1:0] fill_last, fill_last_next;
  logic [CELL_W-1:0] fill_value, fill_value_next;
  logic [3:0]        fill_ret, fill_ret_next;

  // scroll sweep: read one row down, write it back in the following cycle
  logic [ADDR_W-1:0] scan_addr, scan_addr_next;
  logic              pend_valid, pend_valid_next;
  logic [ADDR_W-1:0] pend_addr, pend_addr_next;

  // result held while the output register is still full
  logic [CELL_W-1:0] res_value, res_value_next;
  logic              res_err, res_err_next;

  // memory port
  tccw_pkg::ram_wr_t wr;
  logic [ADDR_W-1:0] rd_addr;
  logic [CELL_W-1:0] rd_data;

  // per-cycle control
  logic              in_accept;
  logic              slot_free;
  logic              done;
  logic [CELL_W-1:0] val_d;
  logic              err_d;
  logic              load_out;
  logic [CELL_W-1:0] load_value;
  logic              load_err;

  // emit helpers
  logic              wrap;
  logic [COL_W-1:0]  col_w;
  logic [ROW_W-1:0]  row_w;
  logic [7:0]        emit_ch;
  logic [CELL_W-1:0] blank;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign blank     = tccw_pkg::make_cell(tccw_pkg::SPACE_CODE, text_color, back_color);

  // wrap the column before a character lands
  assign wrap    = (cur_col >= COL_W'(COLS));
  assign col_w   = wrap ? '0 : cur_col;
  assign row_w   = wrap ? ROW_W'(cur_row + 1'b1) : cur_row;
  assign emit_ch = (ch_r == tccw_pkg::TAB_CODE) ? tccw_pkg::SPACE_CODE : ch_r;

  tccw_screen_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_next      = state;
    cur_col_next    = cur_col;
    cur_row_next    = cur_row;
    tab_left_next   = tab_left;
    mx_next         = mx;
    my_next         = my;
    fill_addr_next  = fill_addr;
    fill_last_next  = fill_last;
    fill_value_next = fill_value;
    fill_ret_next   = fill_ret;
    scan_addr_next  = scan_addr;
    pend_valid_next = pend_valid;
    pend_addr_next  = pend_addr;
    res_value_next  = res_value;
    res_err_next    = res_err;
    wr              = '{en: 1'b0, addr: '0, data: '0};
    rd_addr         = scan_addr;
    done            = 1'b0;
    val_d           = '0;
    err_d           = 1'b0;
    load_out        = 1'b0;
    load_value      = res_value;
    load_err        = res_err;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          // a tab emits one space now and the rest from the repeat count
          state_next    = (op == tccw_pkg::OP_PUT_CHAR) ? S_EMIT : S_DECODE;
          tab_left_next = (char_code == tccw_pkg::TAB_CODE) ?
                          TAB_W'(tccw_pkg::TAB_SPACES - 1) : '0;
        end
      end

      S_DECODE: begin
        case (op_r)
          tccw_pkg::OP_PUT_AT: begin
            if (px_r >= 8'(COLS) || py_r >= 8'(ROWS)) begin
              err_d = 1'b1;
            end else begin
              wr.en   = 1'b1;
              wr.addr = cell_addr(py_r[ROW_W-1:0], px_r[COL_W-1:0]);
              wr.data = tccw_pkg::make_cell(ch_r, fg_r, bg_r);
            end
            done = 1'b1;
          end
          tccw_pkg::OP_SET_CURSOR: begin
            mx_next    = px_r;
            my_next    = py_r;
            state_next = S_MOD;
          end
          tccw_pkg::OP_CLEAR_SCREEN: begin
            cur_col_next    = '0;
            cur_row_next    = '0;
            fill_addr_next  = '0;
            fill_last_next  = LAST_ADDR;
            fill_value_next = blank;
            fill_ret_next   = S_RESP;
            state_next      = S_FILL;
          end
          tccw_pkg::OP_CLEAR_LINE: begin
            if (py_r >= 8'(ROWS)) begin
              err_d = 1'b1;
              done  = 1'b1;
            end else begin
              fill_addr_next  = cell_addr(py_r[ROW_W-1:0], '0);
              fill_last_next  = cell_addr(py_r[ROW_W-1:0], COL_W'(COLS - 1));
              fill_value_next = blank;
              fill_ret_next   = S_RESP;
              state_next      = S_FILL;
            end
          end
          tccw_pkg::OP_READ_CELL: begin
            if (px_r >= 8'(COLS) || py_r >= 8'(ROWS)) begin
              err_d = 1'b1;
              done  = 1'b1;
            end else begin
              rd_addr    = cell_addr(py_r[ROW_W-1:0], px_r[COL_W-1:0]);
              state_next = S_RDWAIT;
            end
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end

      S_EMIT: begin
        if (row_w >= ROW_W'(ROWS)) begin
          // scroll first, then come back here to place the character
          cur_col_next    = col_w;
          cur_row_next    = ROW_W'(ROWS - 1);
          scan_addr_next  = ADDR_W'(COLS);
          pend_valid_next = 1'b0;
          state_next      = S_SCROLL;
        end else begin
          if (emit_ch == tccw_pkg::NEWLINE_CODE) begin
            cur_col_next = '0;
            cur_row_next = ROW_W'(row_w + 1'b1);
          end else begin
            wr.en        = 1'b1;
            wr.addr      = cell_addr(row_w, col_w);
            wr.data      = tccw_pkg::make_cell(emit_ch, text_color, back_color);
            cur_col_next = COL_W'(col_w + 1'b1);
            cur_row_next = row_w;
          end
          if (tab_left != '0) begin
            tab_left_next = TAB_W'(tab_left - 1'b1);
          end else begin
            done = 1'b1;
          end
        end
      end

      S_SCROLL: begin
        if (pend_valid) begin
          wr.en   = 1'b1;
          wr.addr = pend_addr;
          wr.data = rd_data;
        end
        rd_addr         = scan_addr;
        pend_valid_next = 1'b1;
        pend_addr_next  = ADDR_W'(scan_addr - ADDR_W'(COLS));
        if (scan_addr == LAST_ADDR) begin
          state_next = S_SCROLL_END;
        end else begin
          scan_addr_next = ADDR_W'(scan_addr + 1'b1);
        end
      end

      S_SCROLL_END: begin
        // last copied cell, then blank the new bottom row
        if (pend_valid) begin
          wr.en   = 1'b1;
          wr.addr = pend_addr;
          wr.data = rd_data;
        end
        pend_valid_next = 1'b0;
        fill_addr_next  = cell_addr(ROW_W'(ROWS - 1), '0);
        fill_last_next  = LAST_ADDR;
        fill_value_next = blank;
        fill_ret_next   = S_EMIT;
        state_next      = S_FILL;
      end

      S_FILL: begin
        wr.en   = 1'b1;
        wr.addr = fill_addr;
        wr.data = fill_value;
        if (fill_addr == fill_last) begin
          if (fill_ret == S_RESP) begin
            done = 1'b1;
          end else begin
            state_next = fill_ret;
          end
        end else begin
          fill_addr_next = ADDR_W'(fill_addr + 1'b1);
        end
      end

      S_MOD: begin
        // one subtraction per cycle on each coordinate
        if (mx >= 8'(COLS)) begin
          mx_next = 8'(mx - 8'(COLS));
        end
        if (my >= 8'(ROWS)) begin
          my_next = 8'(my - 8'(ROWS));
        end
        if (mx < 8'(COLS) && my < 8'(ROWS)) begin
          cur_col_next = mx[COL_W-1:0];
          cur_row_next = my[ROW_W-1:0];
          done         = 1'b1;
        end
      end

      S_RDWAIT: begin
        val_d = rd_data;
        done  = 1'b1;
      end

      S_RESP: begin
        if (slot_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // hand the result to the output register, or park it until there is room
    if (done) begin
      res_value_next = val_d;
      res_err_next   = err_d;
      load_value     = val_d;
      load_err       = err_d;
      if (slot_free) begin
        load_out   = 1'b1;
        state_next = S_IDLE;
      end else begin
        state_next = S_RESP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      cur_col    <= '0;
      cur_row    <= '0;
      tab_left   <= '0;
      fill_addr  <= '0;
      fill_last  <= LAST_ADDR;
      fill_value <= tccw_pkg::RESET_BLANK;
      fill_ret   <= S_IDLE;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cur_col    <= cur_col_next;
      cur_row    <= cur_row_next;
      tab_left   <= tab_left_next;
      fill_addr  <= fill_addr_next;
      fill_last  <= fill_last_next;
      fill_value <= fill_value_next;
      fill_ret   <= fill_ret_next;
      pend_valid <= pend_valid_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= 4'd15;
      back_color <= 4'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        tccw_pkg::REG_TEXT_COLOR: text_color <= cfg_data;
        tccw_pkg::REG_BACK_COLOR: back_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r <= op;
      ch_r <= char_code;
      fg_r <= cell_text_color;
      bg_r <= cell_back_color;
      px_r <= pos_x;
      py_r <= pos_y;
    end
    mx        <= mx_next;
    my        <= my_next;
    scan_addr <= scan_addr_next;
    pend_addr <= pend_addr_next;
    res_value <= res_value_next;
    res_err   <= res_err_next;
    if (load_out) begin
      cursor_x    <= 7'(cur_col_next);
      cursor_y    <= 5'(cur_row_next);
      cell_value  <= load_value;
      range_error <= load_err;
    end
  end

  // cursor never goes past the pending-wrap or pending-scroll position
  `TCCW_ASSERT_NOW(a_cursor_bound, clk, rst, 1'b1, cur_col <= COL_W'(COLS) && cur_row <= ROW_W'(ROWS), "cursor out of bounds")
  // every memory write lands inside the screen
  `TCCW_ASSERT_NOW(a_write_in_range, clk, rst, wr.en, wr.addr <= LAST_ADDR, "cell write out of range")
  // an accepted item always takes ready low in the following cycle
  `TCCW_ASSERT_NEXT(a_accept_busy, clk, rst, in_accept, !in_ready, "ready after accept")
  // a parked result only exists while the output register is full
  `TCCW_ASSERT_NOW(a_resp_full, clk, rst, state == S_RESP, out_valid, "parked result with empty output")

endmodule
